// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the edge magnitude RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent and consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/sem_pkg.sv -----
// Package with sizes, types and helper functions of the Sobel edge magnitude block.
`timescale 1ns / 1ps

package sem_pkg;

	// Frame limits and field widths.
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 4096;
	localparam int RESET_WIDTH  = 1024;
	localparam int RESET_HEIGHT = 1024;
	localparam int NUM_LANES    = 3;
	localparam int PIX_W        = 8;
	localparam int WIDTH_W      = 11;
	localparam int HEIGHT_W     = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int ADDR_W       = $clog2(MAX_WIDTH);

	// Arithmetic widths: gradients, squared norm, root and remainder.
	localparam int GRAD_W = 11;
	localparam int NORM_W = 21;
	localparam int ROOT_W = 8;
	localparam int REM_W  = 9;

	// Index of the last lane pipeline stage; the output register follows it.
	localparam int LAST_ST = 7;

	// Norms above this value give a magnitude of 255 or more.
	localparam logic [NORM_W-1:0] ROOT_LIMIT = NORM_W'(65280);
	localparam logic [ROOT_W-1:0] EDGE_MAX   = ROOT_W'(255);

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;

	typedef logic [NUM_LANES*PIX_W-1:0] rgb_t;
	typedef logic [8:0][PIX_W-1:0] win9_t;
	typedef logic [NUM_LANES-1:0][8:0][PIX_W-1:0] win_t;

	// Pipeline control handed from the top level to the window and the lanes.
	typedef struct packed {
		logic               accept;
		logic               shift;
		logic [LAST_ST:2]   ld;
	} pipe_ctl_t;

	// Partial state of the digit-by-digit square root.
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_st_t;

	// A width of zero acts as one, a width above the limit acts as the limit.
	function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] v);
		logic [WIDTH_W-1:0] r;
		if (v == '0) begin
			r = WIDTH_W'(1);
		end else if (v > WIDTH_W'(MAX_WIDTH)) begin
			r = WIDTH_W'(MAX_WIDTH);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Same clamping for the height.
	function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] v);
		logic [HEIGHT_W-1:0] r;
		if (v == '0) begin
			r = HEIGHT_W'(1);
		end else if (v > HEIGHT_W'(MAX_HEIGHT)) begin
			r = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// One root bit: bring down two radicand bits and try to subtract 4*root+1.
	function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [1:0] d);
		logic [REM_W+1:0] rem_sh;
		logic [REM_W+1:0] trial;
		sqrt_st_t         o;
		rem_sh = {s.rem, d};
		trial  = {1'b0, s.root, 2'b01};
		if (rem_sh >= trial) begin
			o.rem  = REM_W'(rem_sh - trial);
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = rem_sh[REM_W-1:0];
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

// ----- rtl/sem_window.sv -----
// Position counters, two-row line store and 3x3 window feeding the lanes.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sem_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sem_pkg::pipe_ctl_t         ctl,
	input  logic [sem_pkg::WIDTH_W-1:0]  width_eff,
	input  logic [sem_pkg::HEIGHT_W-1:0] height_eff,
	input  sem_pkg::rgb_t              pix,
	output sem_pkg::win_t              win,
	output logic                       emit_s1,
	output logic                       last_s1
);
	import sem_pkg::*;

	logic [WIDTH_W-1:0]  col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic                col_ok;
	logic                pix_ok;
	logic [ADDR_W-1:0]   addr;
	rgb_t                cur;

	rgb_t bank0_mem [MAX_WIDTH];
	rgb_t bank1_mem [MAX_WIDTH];

	rgb_t rd0_s1;
	rgb_t rd1_s1;
	rgb_t cur_s1;
	logic bank_s1;
	logic top_en_s1;
	logic mid_en_s1;
	logic clr_s1;

	rgb_t col_px [3];
	rgb_t old0   [3];
	rgb_t old1   [3];
	rgb_t win_q  [6];

	// Position of the arriving word on the padded grid.
	assign col_ok = col_q < width_eff;
	assign pix_ok = col_ok && (row_q < height_eff);
	assign addr   = col_q[ADDR_W-1:0];
	assign cur    = pix_ok ? pix : '0;

	// Column and row counters step once per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.accept) begin
			if (col_q >= width_eff) begin
				col_q <= '0;
				row_q <= (row_q >= height_eff) ? '0 : row_q + HEIGHT_W'(1);
			end else begin
				col_q <= col_q + WIDTH_W'(1);
			end
		end
	end

	// Line store: the bank of the current row parity is read first, then overwritten.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			rd0_s1 <= bank0_mem[addr];
			rd1_s1 <= bank1_mem[addr];
			if (col_ok && !row_q[0]) begin
				bank0_mem[addr] <= cur;
			end
			if (col_ok && row_q[0]) begin
				bank1_mem[addr] <= cur;
			end
		end
	end

	// Flags for the word entering stage one.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cur_s1    <= cur;
			bank_s1   <= row_q[0];
			top_en_s1 <= col_ok && (row_q >= HEIGHT_W'(2));
			mid_en_s1 <= col_ok && (row_q >= HEIGHT_W'(1));
			clr_s1    <= (col_q == '0);
			emit_s1   <= (row_q >= HEIGHT_W'(1)) && (col_q >= WIDTH_W'(1));
			last_s1   <= (row_q == height_eff) && (col_q == width_eff);
		end
	end

	// Newest column from the line store, with rows above the image masked to zero.
	always_comb begin
		col_px[0] = top_en_s1 ? (bank_s1 ? rd1_s1 : rd0_s1) : '0;
		col_px[1] = mid_en_s1 ? (bank_s1 ? rd0_s1 : rd1_s1) : '0;
		col_px[2] = cur_s1;
		for (int q = 0; q < 3; q++) begin
			old0[q] = clr_s1 ? '0 : win_q[q*2];
			old1[q] = clr_s1 ? '0 : win_q[q*2+1];
		end
	end

	// Split the window into one 3x3 patch per color lane.
	always_comb begin
		for (int c = 0; c < NUM_LANES; c++) begin
			for (int q = 0; q < 3; q++) begin
				win[c][q*3]   = old0[q][c*PIX_W +: PIX_W];
				win[c][q*3+1] = old1[q][c*PIX_W +: PIX_W];
				win[c][q*3+2] = col_px[q][c*PIX_W +: PIX_W];
			end
		end
	end

	// Window columns shift as the word leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) begin
				win_q[k] <= '0;
			end
		end else if (ctl.shift) begin
			for (int q = 0; q < 3; q++) begin
				win_q[q*2]   <= old1[q];
				win_q[q*2+1] <= col_px[q];
			end
		end
	end

	`ASSERT_NEXT(a_row_wrap, ctl.accept && (col_q >= width_eff), col_q == '0)
	`ASSERT_IMPLY(a_emit_not_first_col, ctl.shift && emit_s1, !clr_s1)

endmodule

// ----- rtl/sem_lane.sv -----
// One color lane: Sobel sums, squared norm and pipelined rounded square root.
`timescale 1ns / 1ps

module sem_lane (
	input  logic                       clk,
	input  sem_pkg::pipe_ctl_t         ctl,
	input  sem_pkg::win9_t             px,
	output logic [sem_pkg::ROOT_W-1:0] magnitude
);
	import sem_pkg::*;

	logic [PIX_W+1:0]         pos_x;
	logic [PIX_W+1:0]         neg_x;
	logic [PIX_W+1:0]         pos_y;
	logic [PIX_W+1:0]         neg_y;
	logic signed [GRAD_W-1:0] gx;
	logic signed [GRAD_W-1:0] gy;

	logic signed [GRAD_W-1:0]   gx_s2;
	logic signed [GRAD_W-1:0]   gy_s2;
	logic signed [2*GRAD_W-1:0] sq_x;
	logic signed [2*GRAD_W-1:0] sq_y;
	logic [NORM_W-1:0]          norm;

	logic [NORM_W-1:0] norm_s3;
	sqrt_st_t          st3_a;
	sqrt_st_t          st3_b;

	sqrt_st_t    st_s4;
	logic [11:0] n_s4;
	logic        big_s4;
	sqrt_st_t    st_s5;
	logic [7:0]  n_s5;
	logic        big_s5;
	sqrt_st_t    st_s6;
	logic [3:0]  n_s6;
	logic        big_s6;
	sqrt_st_t    st_s7;
	logic        big_s7;

	// Sobel sums, positive and negative taps added separately.
	always_comb begin
		pos_x = {2'b00, px[2]} + {1'b0, px[5], 1'b0} + {2'b00, px[8]};
		neg_x = {2'b00, px[0]} + {1'b0, px[3], 1'b0} + {2'b00, px[6]};
		pos_y = {2'b00, px[6]} + {1'b0, px[7], 1'b0} + {2'b00, px[8]};
		neg_y = {2'b00, px[0]} + {1'b0, px[1], 1'b0} + {2'b00, px[2]};
		gx    = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
		gy    = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[2]) begin
			gx_s2 <= gx;
			gy_s2 <= gy;
		end
	end

	// Squared norm; each square stays below 2^20.
	assign sq_x = gx_s2 * gx_s2;
	assign sq_y = gy_s2 * gy_s2;
	assign norm = {1'b0, sq_x[NORM_W-2:0]} + {1'b0, sq_y[NORM_W-2:0]};

	always_ff @(posedge clk) begin
		if (ctl.ld[3]) begin
			norm_s3 <= norm;
		end
	end

	// Root bits seven and six from the top radicand pairs.
	always_comb begin
		st3_a = sqrt_step('0, norm_s3[15:14]);
		st3_b = sqrt_step(st3_a, norm_s3[13:12]);
	end

	// Two root bits per stage through stage seven.
	always_ff @(posedge clk) begin
		if (ctl.ld[4]) begin
			st_s4  <= st3_b;
			n_s4   <= norm_s3[11:0];
			big_s4 <= norm_s3 > ROOT_LIMIT;
		end
		if (ctl.ld[5]) begin
			st_s5  <= sqrt_step(sqrt_step(st_s4, n_s4[11:10]), n_s4[9:8]);
			n_s5   <= n_s4[7:0];
			big_s5 <= big_s4;
		end
		if (ctl.ld[6]) begin
			st_s6  <= sqrt_step(sqrt_step(st_s5, n_s5[7:6]), n_s5[5:4]);
			n_s6   <= n_s5[3:0];
			big_s6 <= big_s5;
		end
		if (ctl.ld[7]) begin
			st_s7  <= sqrt_step(sqrt_step(st_s6, n_s6[3:2]), n_s6[1:0]);
			big_s7 <= big_s6;
		end
	end

	// Round to nearest: up when the remainder exceeds the root; clamp large norms.
	always_comb begin
		if (big_s7) begin
			magnitude = EDGE_MAX;
		end else if (st_s7.rem > REM_W'(st_s7.root)) begin
			magnitude = st_s7.root + ROOT_W'(1);
		end else begin
			magnitude = st_s7.root;
		end
	end

endmodule

// ----- rtl/sobel_edge_magnitude_rgb_core.sv -----
// Top level of the RGB Sobel edge magnitude block: configuration, pipeline control, merge.
//
//   channel   signals                                         direction
//   input     in_valid/in_ready, red_in, green_in, blue_in     into block
//   output    out_valid/out_ready, red_edge, green_edge,       out of block
//             blue_edge, frame_end
//   config    cfg_write, cfg_index, cfg_data                   into block, write only
//
// One word is accepted per clock while in_ready is high. The line store read is registered,
// and the three color lanes run a pipeline whose square root resolves two bits per stage,
// followed by the output register.
// Reset clears the counters, the window and all valid bits; the frame size resets to 1024x1024.
// While out_ready is low the stages keep filling; in_ready drops once all are occupied.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sobel_edge_magnitude_rgb_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic                           cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sem_pkg::PIX_W-1:0]      red_in,
	input  logic [sem_pkg::PIX_W-1:0]      green_in,
	input  logic [sem_pkg::PIX_W-1:0]      blue_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sem_pkg::PIX_W-1:0]      red_edge,
	output logic [sem_pkg::PIX_W-1:0]      green_edge,
	output logic [sem_pkg::PIX_W-1:0]      blue_edge,
	output logic                           frame_end
);
	import sem_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;

	logic [LAST_ST+1:1] ld;
	logic [LAST_ST:1]   v_q;
	logic [LAST_ST:2]   emit_q;
	logic [LAST_ST:2]   last_q;
	pipe_ctl_t          ctl;

	win_t                         win;
	logic                         emit_s1;
	logic                         last_s1;
	logic [NUM_LANES-1:0][ROOT_W-1:0] mag;

	logic               out_valid_q;
	logic [PIX_W-1:0]   red_q;
	logic [PIX_W-1:0]   green_q;
	logic [PIX_W-1:0]   blue_q;
	logic               frame_end_q;

	// Frame size registers hold the clamped size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(RESET_WIDTH);
			height_q <= HEIGHT_W'(RESET_HEIGHT);
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_IMAGE_WIDTH: begin
					width_q <= eff_width(cfg_data[WIDTH_W-1:0]);
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= eff_height(cfg_data[HEIGHT_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// A stage loads when it is empty or its word moves on.
	always_comb begin
		ld[LAST_ST+1] = !out_valid_q || out_ready;
		for (int k = LAST_ST; k >= 1; k--) begin
			ld[k] = ld[k+1] || !v_q[k];
		end
	end

	assign in_ready   = ld[1];
	assign ctl.accept = in_valid && ld[1];
	assign ctl.shift  = v_q[1] && ld[2];
	assign ctl.ld     = ld[LAST_ST:2];

	// Valid bits and frame flags travel alongside the lane stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			emit_q <= '0;
			last_q <= '0;
		end else begin
			if (ld[1]) begin
				v_q[1] <= in_valid;
			end
			if (ld[2]) begin
				v_q[2]    <= v_q[1];
				emit_q[2] <= emit_s1;
				last_q[2] <= last_s1;
			end
			for (int k = 3; k <= LAST_ST; k++) begin
				if (ld[k]) begin
					v_q[k]    <= v_q[k-1];
					emit_q[k] <= emit_q[k-1];
					last_q[k] <= last_q[k-1];
				end
			end
		end
	end

	sem_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.width_eff (width_q),
		.height_eff(height_q),
		.pix       ({blue_in, green_in, red_in}),
		.win       (win),
		.emit_s1   (emit_s1),
		.last_s1   (last_s1)
	);

	// One lane per color.
	for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
		sem_lane u_lane (
			.clk      (clk),
			.ctl      (ctl),
			.px       (win[c]),
			.magnitude(mag[c])
		);
	end

	// Merge the lane results into the output word; words with no result are dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld[LAST_ST+1]) begin
			out_valid_q <= v_q[LAST_ST] && emit_q[LAST_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[LAST_ST+1]) begin
			red_q       <= mag[0];
			green_q     <= mag[1];
			blue_q      <= mag[2];
			frame_end_q <= last_q[LAST_ST];
		end
	end

	assign out_valid  = out_valid_q;
	assign red_edge   = red_q;
	assign green_edge = green_q;
	assign blue_edge  = blue_q;
	assign frame_end  = frame_end_q;

	`ASSERT_IMPLY(a_stall_only_when_full, !in_ready, out_valid && !out_ready)
	`ASSERT_IMPLY(a_out_from_last_stage, $rose(out_valid_q), $past(v_q[LAST_ST] && emit_q[LAST_ST]))

endmodule
